[rtl/dda_pkg.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, command and register codes, and the divider status word.
// ----------------------------------------------------------------------------
package dda_pkg;

   // Frame dimension registers and the framebuffer word address.
   localparam int DIM_BITS  = 14;
   localparam int ADDR_BITS = 26;
   localparam int COLOR_BITS = 32;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = 14'd800;
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 14'd600;

   // Request commands.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Status of the shared step divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/dda_div.sv]
// ----------------------------------------------------------------------------
// DDA step divider
// Restoring divider, one compare and subtract per cycle, giving the step
// magnitude dividend * 2^FRAC_BITS / divisor rounded half away from zero.
// ----------------------------------------------------------------------------
module dda_div #(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [COORD_BITS-1:0]        dividend,
   input  logic [COORD_BITS-1:0]        divisor,
   output dda_pkg::div_status_type      status,
   output logic [FRAC_BITS:0]           quotient
);
   import dda_pkg::*;

   localparam int CNTW = $clog2(FRAC_BITS + 2);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic [COORD_BITS:0]   rem_ff;
   logic [COORD_BITS-1:0] dvs_ff;
   logic [FRAC_BITS+1:0]  quo_ff;

   logic                  fits;
   logic [COORD_BITS:0]   diff;
   logic [COORD_BITS:0]   rem_sel;
   logic [COORD_BITS:0]   rem_in;
   logic [FRAC_BITS+1:0]  quo_in;
   logic [FRAC_BITS+1:0]  quo_round;
   logic                  last_step;

   // The quotient carries one extra fraction bit; adding one and halving
   // gives round to nearest with ties away from zero.
   always_comb begin
      fits      = rem_ff >= {1'b0, dvs_ff};
      diff      = rem_ff - {1'b0, dvs_ff};
      rem_sel   = fits ? diff : rem_ff;
      rem_in    = {rem_sel[COORD_BITS-1:0], 1'b0};
      quo_in    = {quo_ff[FRAC_BITS:0], fits};
      quo_round = quo_ff + (FRAC_BITS+2)'(1);
      last_step = cnt_ff == CNTW'(FRAC_BITS + 1);
   end

   assign quotient    = quo_round[FRAC_BITS+1:1];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= {1'b0, dividend};
         dvs_ff  <= divisor;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNTW'(1);
         if (last_step) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

endmodule

[rtl/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Steps a fixed-point cursor along a line and emits one framebuffer pixel
// per tick command, with clipping and a word address.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries command words. A start word loads both
// endpoints and the color and produces no rsp_ word. The block then derives
// the x and y steps with one shared restoring divider, x first and y second,
// one quotient bit per cycle. req_ready stays low once a start word with
// unequal endpoints is taken, until both steps are loaded.
// A tick word while a line is active yields one rsp_ word, registered, on the
// cycle after it is accepted; ticks are taken one per cycle. A tick while no
// line is active, and a start with equal endpoints, produce nothing. The end
// point itself is never emitted; the final pixel carries rsp_last.
// When the receiver stalls, the pending rsp_ word holds and req_ready stays
// low until that word is taken. The csr_ channel writes frame_width (index 0)
// and frame_height (index 1) and is always ready; write it only while idle.
// Reset clears the line, drops any pending rsp_ word and restores an
// 800 by 600 frame.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Command words.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic signed [COORD_BITS-1:0]        req_start_x,
   input  logic signed [COORD_BITS-1:0]        req_start_y,
   input  logic signed [COORD_BITS-1:0]        req_end_x,
   input  logic signed [COORD_BITS-1:0]        req_end_y,
   input  logic [dda_pkg::COLOR_BITS-1:0]      req_line_color,
   // Pixel words.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_y,
   output logic [dda_pkg::COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                                rsp_in_frame,
   output logic [dda_pkg::ADDR_BITS-1:0]       rsp_frame_address,
   output logic                                rsp_last,
   // Register writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dda_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dda_pkg::DIM_BITS-1:0]        csr_data
);
   import dda_pkg::*;

   // Cursor: sign, COORD_BITS+1 integer bits to cover overshoot, fraction.
   localparam int CW   = COORD_BITS + FRAC_BITS + 2;
   localparam int SW   = FRAC_BITS + 2;
   localparam int CMPW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   state_type                    state_ff;
   logic                         active_ff;
   logic signed [CW-1:0]         cursor_x_ff;
   logic signed [CW-1:0]         cursor_y_ff;
   logic signed [SW-1:0]         step_x_ff;
   logic signed [SW-1:0]         step_y_ff;
   logic [COORD_BITS-1:0]        pixels_left_ff;
   logic [COLOR_BITS-1:0]        held_color_ff;
   logic signed [COORD_BITS-1:0] px_ff;
   logic signed [COORD_BITS-1:0] py_ff;
   logic                         neg_x_ff;
   logic                         neg_y_ff;
   logic [COORD_BITS-1:0]        abs_y_ff;
   logic [COORD_BITS-1:0]        span_ff;
   logic [DIM_BITS-1:0]          frame_width_ff;
   logic [DIM_BITS-1:0]          frame_height_ff;

   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_pixel_x_ff;
   logic signed [COORD_BITS-1:0] rsp_pixel_y_ff;
   logic [COLOR_BITS-1:0]        rsp_pixel_color_ff;
   logic                         rsp_in_frame_ff;
   logic [ADDR_BITS-1:0]         rsp_frame_address_ff;
   logic                         rsp_last_ff;

   logic                         req_fire;
   logic                         start_fire;
   logic                         tick_fire;
   logic signed [COORD_BITS:0]   dx;
   logic signed [COORD_BITS:0]   dy;
   logic [COORD_BITS-1:0]        abs_x;
   logic [COORD_BITS-1:0]        abs_y;
   logic [COORD_BITS-1:0]        span;
   logic                         span_zero;

   logic                         div_start;
   logic [COORD_BITS-1:0]        div_dividend;
   logic [COORD_BITS-1:0]        div_divisor;
   div_status_type               div_status;
   logic [FRAC_BITS:0]           div_quotient;
   logic signed [SW-1:0]         div_step;

   logic signed [CW-1:0]         cursor_x_in;
   logic signed [CW-1:0]         cursor_y_in;
   logic                         in_frame_now;
   logic [DIM_BITS-1:0]          px_lo;
   logic [DIM_BITS-1:0]          py_lo;
   logic [2*DIM_BITS-1:0]        addr_full;

   // Fixed point to integer, half away from zero, saturated to COORD_BITS.
   // For a negative cursor the bias is one less, which turns the floor of
   // the arithmetic shift into the wanted rounding.
   function automatic logic signed [COORD_BITS-1:0] round_sat(
      input logic signed [CW-1:0] c
   );
      logic signed [CW-1:0]         biased;
      logic signed [COORD_BITS+1:0] whole;
      logic signed [COORD_BITS+1:0] hi_lim;
      logic signed [COORD_BITS+1:0] lo_lim;
      biased = c + (CW'(1) <<< (FRAC_BITS - 1)) - CW'(c[CW-1]);
      whole  = biased[CW-1:FRAC_BITS];
      hi_lim = {3'b000, {(COORD_BITS-1){1'b1}}};
      lo_lim = {3'b111, {(COORD_BITS-1){1'b0}}};
      if (whole > hi_lim) begin
         return hi_lim[COORD_BITS-1:0];
      end else if (whole < lo_lim) begin
         return lo_lim[COORD_BITS-1:0];
      end
      return whole[COORD_BITS-1:0];
   endfunction

   // Handshakes. A new word is taken only when the pixel register is free
   // or being emptied in this cycle.
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign start_fire = req_fire && (req_command == CMD_START);
   assign tick_fire  = req_fire && (req_command == CMD_TICK) && active_ff;
   assign csr_ready  = 1'b1;

   // Line setup: deltas, their magnitudes and the longer span.
   always_comb begin
      dx        = (COORD_BITS+1)'(req_end_x) - (COORD_BITS+1)'(req_start_x);
      dy        = (COORD_BITS+1)'(req_end_y) - (COORD_BITS+1)'(req_start_y);
      abs_x     = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
      abs_y     = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
      span      = (abs_x >= abs_y) ? abs_x : abs_y;
      span_zero = span == '0;
   end

   // The divider runs twice per line: x from the start word itself, y as
   // soon as x finishes.
   always_comb begin
      div_start    = (start_fire && !span_zero) ||
                     (state_ff == ST_DIV_X && div_status.done);
      div_dividend = (state_ff == ST_IDLE) ? abs_x : abs_y_ff;
      div_divisor  = (state_ff == ST_IDLE) ? span : span_ff;
      if (state_ff == ST_DIV_X) begin
         div_step = neg_x_ff ? -SW'(div_quotient) : SW'(div_quotient);
      end else begin
         div_step = neg_y_ff ? -SW'(div_quotient) : SW'(div_quotient);
      end
   end

   dda_div #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Pixel generation. The rounded position of the current cursor is kept
   // ready in px_ff/py_ff, so a tick only clips and forms the address.
   always_comb begin
      cursor_x_in = cursor_x_ff + CW'(step_x_ff);
      cursor_y_in = cursor_y_ff + CW'(step_y_ff);
      in_frame_now = !px_ff[COORD_BITS-1] && !py_ff[COORD_BITS-1] &&
                     (CMPW'($unsigned(px_ff)) < CMPW'(frame_width_ff)) &&
                     (CMPW'($unsigned(py_ff)) < CMPW'(frame_height_ff));
      // Inside the frame both coordinates are below 2^DIM_BITS.
      px_lo     = DIM_BITS'($unsigned(px_ff));
      py_lo     = DIM_BITS'($unsigned(py_ff));
      addr_full = frame_width_ff * py_lo + (2*DIM_BITS)'(px_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
               default: ;
            endcase
         end

         if (rsp_ready && !tick_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (start_fire) begin
                  // A start replaces any line in progress.
                  held_color_ff  <= req_line_color;
                  cursor_x_ff    <= CW'(req_start_x) <<< FRAC_BITS;
                  cursor_y_ff    <= CW'(req_start_y) <<< FRAC_BITS;
                  px_ff          <= req_start_x;
                  py_ff          <= req_start_y;
                  pixels_left_ff <= span;
                  span_ff        <= span;
                  abs_y_ff       <= abs_y;
                  neg_x_ff       <= dx[COORD_BITS];
                  neg_y_ff       <= dy[COORD_BITS];
                  active_ff      <= 1'b0;
                  if (!span_zero) begin
                     state_ff <= ST_DIV_X;
                  end
               end else if (tick_fire) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_pixel_x_ff       <= px_ff;
                  rsp_pixel_y_ff       <= py_ff;
                  rsp_pixel_color_ff   <= held_color_ff;
                  rsp_in_frame_ff      <= in_frame_now;
                  rsp_frame_address_ff <= in_frame_now ? addr_full[ADDR_BITS-1:0] : '0;
                  rsp_last_ff          <= pixels_left_ff == COORD_BITS'(1);
                  cursor_x_ff          <= cursor_x_in;
                  cursor_y_ff          <= cursor_y_in;
                  px_ff                <= round_sat(cursor_x_in);
                  py_ff                <= round_sat(cursor_y_in);
                  pixels_left_ff       <= pixels_left_ff - COORD_BITS'(1);
                  if (pixels_left_ff == COORD_BITS'(1)) begin
                     active_ff <= 1'b0;
                  end
               end
            end
            ST_DIV_X: begin
               if (div_status.done) begin
                  step_x_ff <= div_step;
                  state_ff  <= ST_DIV_Y;
               end
            end
            ST_DIV_Y: begin
               if (div_status.done) begin
                  step_y_ff <= div_step;
                  active_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = rsp_pixel_x_ff;
   assign rsp_pixel_y       = rsp_pixel_y_ff;
   assign rsp_pixel_color   = rsp_pixel_color_ff;
   assign rsp_in_frame      = rsp_in_frame_ff;
   assign rsp_frame_address = rsp_frame_address_ff;
   assign rsp_last          = rsp_last_ff;

   // A pixel word appears only after an accepted tick on an active line.
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tick_fire))
      else $error("pixel word without an accepted tick");

   // The divider never runs while commands are being taken.
   a_div_not_idle: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff != ST_IDLE))
      else $error("divider busy while the sequencer is idle");

   // An active line always has pixels left to emit.
   a_active_count: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (pixels_left_ff != '0))
      else $error("active line with no pixels left");

   // The final pixel ends the line.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (tick_fire && pixels_left_ff == COORD_BITS'(1)) |=> !active_ff)
      else $error("line still active after its final pixel");

endmodule

[test/dda_line_rasterizer_tb.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Feeds start and tick command words to the rasterizer, tracks every line in
// a cycle-free model of its own and checks each pixel word that comes back,
// over several frame sizes, with random gaps on the command side and random
// stalls and a long hold-off on the pixel side.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;
   import dda_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_BITS  = 16;
   localparam int CURSOR_BITS = COORD_BITS + FRAC_BITS + 2;
   localparam int STEP_BITS   = FRAC_BITS + 2;
   localparam int COUNT_BITS  = COORD_BITS + 1;

   // A start word keeps the divider busy for less than this, so it is also a
   // bound on how long the block can be at work after the last pixel word has left.
   localparam int SETTLE_CYCLES = 2 * (FRAC_BITS + 3) + 10;
   localparam int HOLD_CYCLES   = 200;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 50;

   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   typedef struct {
      logic                         command;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic [COLOR_BITS-1:0]        color;
   } line_word_type;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0]        color;
      logic                         in_frame;
      logic [ADDR_BITS-1:0]         address;
      logic                         last_pixel;
   } pixel_word_type;

   // Block ports. Every input has a known value from time zero on.
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = CMD_TICK;
   logic signed [COORD_BITS-1:0] req_start_x = '0;
   logic signed [COORD_BITS-1:0] req_start_y = '0;
   logic signed [COORD_BITS-1:0] req_end_x = '0;
   logic signed [COORD_BITS-1:0] req_end_y = '0;
   logic [COLOR_BITS-1:0]        req_line_color = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_pixel_x;
   logic signed [COORD_BITS-1:0] rsp_pixel_y;
   logic [COLOR_BITS-1:0]        rsp_pixel_color;
   logic                         rsp_in_frame;
   logic [ADDR_BITS-1:0]         rsp_frame_address;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index = CSR_FRAME_WIDTH;
   logic [DIM_BITS-1:0]          csr_data = '0;

   // Words waiting for the driver, and pixels waiting for the block.
   line_word_type  pending_words[$];
   pixel_word_type expected_pixels[$];

   // Line tracker state, starting from its reset values.
   logic                          line_busy = 1'b0;
   logic signed [CURSOR_BITS-1:0] pos_x = '0;
   logic signed [CURSOR_BITS-1:0] pos_y = '0;
   logic signed [STEP_BITS-1:0]   inc_x = '0;
   logic signed [STEP_BITS-1:0]   inc_y = '0;
   logic [COUNT_BITS-1:0]         pixels_to_go = '0;
   logic [COLOR_BITS-1:0]         line_color_q = '0;
   logic [DIM_BITS-1:0]           frame_width_q = FRAME_WIDTH_RESET;
   logic [DIM_BITS-1:0]           frame_height_q = FRAME_HEIGHT_RESET;

   // Traffic shaping, set by the sequence and read at the falling edge.
   int send_idle_pct = 26;
   int recv_stall_pct = 61;
   int rsp_hold_left = 0;

   bit word_taken = 1'b0;
   int words_queued = 0;
   int words_accepted = 0;
   int starts_accepted = 0;
   int pixels_checked = 0;
   int frame_settings = 1;
   int mismatch_count = 0;
   int cycle_count = 0;

   dda_line_rasterizer #(
      .FRAC_BITS (FRAC_BITS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_line_color   (req_line_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_in_frame     (rsp_in_frame),
      .rsp_frame_address(rsp_frame_address),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Line tracker
   // -------------------------------------------------------------------------

   // Per-axis increment: delta / span in fixed point, rounded to nearest with
   // ties away from zero. The long axis always comes out as exactly one.
   function automatic logic signed [STEP_BITS-1:0] axis_step(longint delta, longint span);
      longint num;
      longint quot;
      num = (delta < 0 ? -delta : delta) << FRAC_BITS;
      quot = (2 * num + span) / (2 * span);
      return STEP_BITS'(delta < 0 ? -quot : quot);
   endfunction

   // Cursor to pixel coordinate, half away from zero, clamped to the port range.
   function automatic longint round_coord(logic signed [CURSOR_BITS-1:0] cursor);
      longint mag;
      longint whole;
      mag = cursor < 0 ? -longint'(cursor) : longint'(cursor);
      whole = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (cursor < 0) begin
         whole = -whole;
      end
      if (whole > COORD_MAX) begin
         whole = COORD_MAX;
      end
      if (whole < COORD_MIN) begin
         whole = COORD_MIN;
      end
      return whole;
   endfunction

   // A start word replaces whatever line was in progress. Equal endpoints
   // leave the block idle.
   function automatic void load_line(line_word_type cmd);
      longint sx;
      longint sy;
      longint dx;
      longint dy;
      longint span;
      sx = longint'(cmd.start_x);
      sy = longint'(cmd.start_y);
      dx = longint'(cmd.end_x) - sx;
      dy = longint'(cmd.end_y) - sy;
      span = (dx < 0 ? -dx : dx);
      if ((dy < 0 ? -dy : dy) > span) begin
         span = (dy < 0 ? -dy : dy);
      end
      line_color_q = cmd.color;
      pos_x = CURSOR_BITS'(sx * (longint'(1) << FRAC_BITS));
      pos_y = CURSOR_BITS'(sy * (longint'(1) << FRAC_BITS));
      line_busy = (span != 0);
      pixels_to_go = COUNT_BITS'(span);
      inc_x = span != 0 ? axis_step(dx, span) : '0;
      inc_y = span != 0 ? axis_step(dy, span) : '0;
   endfunction

   // A tick on an active line yields the pixel under the cursor and moves on.
   // A tick with no line in progress yields nothing.
   function automatic void next_pixel();
      pixel_word_type pix;
      longint x;
      longint y;
      if (!line_busy) begin
         return;
      end
      x = round_coord(pos_x);
      y = round_coord(pos_y);
      pix.x = COORD_BITS'(x);
      pix.y = COORD_BITS'(y);
      pix.color = line_color_q;
      pix.in_frame = x >= 0 && y >= 0 &&
                     x < longint'(frame_width_q) && y < longint'(frame_height_q);
      pix.address = pix.in_frame ? ADDR_BITS'(longint'(frame_width_q) * y + x) : '0;
      pix.last_pixel = (pixels_to_go == 1);
      expected_pixels.push_back(pix);
      pos_x = pos_x + inc_x;
      pos_y = pos_y + inc_y;
      pixels_to_go = pixels_to_go - 1'b1;
      if (pixels_to_go == 0) begin
         line_busy = 1'b0;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------

   // Only the first few mismatches are printed to keep the log short; all of
   // them are counted.
   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("MISMATCH: %s", what);
      end
   endtask

   task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("pixel word %0d, %s: got 0x%0h, want 0x%0h",
                                   pixels_checked, field, got, want));
      end
   endtask

   // -------------------------------------------------------------------------
   // Driver: presents the next pending command word at the falling edge, after
   // an optional random gap, and holds it until the block takes it.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      line_word_type offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offer = pending_words.pop_front();
            req_valid <= 1'b1;
            req_command <= offer.command;
            req_start_x <= offer.start_x;
            req_start_y <= offer.start_y;
            req_end_x <= offer.end_x;
            req_end_y <= offer.end_y;
            req_line_color <= offer.color;
         end else begin
            req_valid <= 1'b0;
         end
      end
      word_taken = 1'b0;
   end

   // Receiver: a pending hold-off overrides the random stalls.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: at each rising edge, a command word taken by the block updates
   // the line tracker, and a pixel word taken from the block is checked
   // against the oldest expected pixel. Both live in one process so that the
   // order of the two within an edge is fixed.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      line_word_type  seen;
      pixel_word_type want;
      if (!reset && req_valid && req_ready) begin
         seen.command = req_command;
         seen.start_x = req_start_x;
         seen.start_y = req_start_y;
         seen.end_x = req_end_x;
         seen.end_y = req_end_y;
         seen.color = req_line_color;
         words_accepted++;
         word_taken = 1'b1;
         if (seen.command == CMD_START) begin
            starts_accepted++;
            load_line(seen);
         end else begin
            next_pixel();
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel word at (%0d,%0d) with no pixel expected",
                                      rsp_pixel_x, rsp_pixel_y));
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_x", rsp_pixel_x, want.x);
            check_field("pixel_y", rsp_pixel_y, want.y);
            check_field("pixel_color", rsp_pixel_color, want.color);
            check_field("in_frame", rsp_in_frame, want.in_frame);
            check_field("frame_address", rsp_frame_address, want.address);
            check_field("last", rsp_last, want.last_pixel);
         end
         pixels_checked++;
      end
   end

   // Watchdog: a hung block must not keep the run going forever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixel words still expected",
                  CYCLE_LIMIT, expected_pixels.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   function automatic int any_coord();
      logic signed [COORD_BITS-1:0] v;
      v = COORD_BITS'($urandom);
      return int'(v);
   endfunction

   function automatic void queue_word(logic command, int sx, int sy, int ex, int ey,
                                      logic [COLOR_BITS-1:0] color);
      line_word_type w;
      w.command = command;
      w.start_x = COORD_BITS'(sx);
      w.start_y = COORD_BITS'(sy);
      w.end_x = COORD_BITS'(ex);
      w.end_y = COORD_BITS'(ey);
      w.color = color;
      pending_words.push_back(w);
      words_queued++;
   endfunction

   // Ticks carry random endpoint fields, which the block must ignore.
   function automatic void queue_tick();
      queue_word(CMD_TICK, any_coord(), any_coord(), any_coord(), any_coord(), $urandom);
   endfunction

   function automatic void queue_line(int sx, int sy, int ex, int ey,
                                      logic [COLOR_BITS-1:0] color, int ticks);
      queue_word(CMD_START, sx, sy, ex, ey, color);
      repeat (ticks) queue_tick();
   endfunction

   // Mostly short lines near the frame, each followed by its ticks; some are
   // cut short by the next start and some get extra ticks after the end.
   // The rest is long lines with random endpoints and raw random words.
   task automatic queue_random_words(int n_words);
      int count;
      int pick;
      int reach;
      int sx;
      int sy;
      int ex;
      int ey;
      int span;
      int ticks;
      int shape;
      count = 0;
      while (count < n_words) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            reach = (pick < 6) ? 120 : 24;
            sx = int'($urandom_range(int'(frame_width_q) + 60)) - 30;
            sy = int'($urandom_range(int'(frame_height_q) + 60)) - 30;
            ex = sx + int'($urandom_range(2 * reach)) - reach;
            ey = sy + int'($urandom_range(2 * reach)) - reach;
            span = (ex > sx) ? ex - sx : sx - ex;
            if (((ey > sy) ? ey - sy : sy - ey) > span) begin
               span = (ey > sy) ? ey - sy : sy - ey;
            end
            shape = $urandom_range(9);
            if (shape < 7) begin
               ticks = span;
            end else if (shape < 9) begin
               ticks = $urandom_range(span);
            end else begin
               ticks = span + int'($urandom_range(3, 1));
            end
            queue_line(sx, sy, ex, ey, $urandom, ticks);
            count += 1 + ((ticks < span) ? ticks : span);
         end else if (pick < 88) begin
            ticks = $urandom_range(4);
            queue_line(any_coord(), any_coord(), any_coord(), any_coord(), $urandom, ticks);
            count += 1 + ticks;
         end else begin
            queue_word(1'($urandom_range(1)), any_coord(), any_coord(), any_coord(),
                       any_coord(), $urandom);
            count++;
         end
      end
   endtask

   // Wait until every queued word has been taken and every expected pixel has
   // arrived, then step to a rising edge so the caller runs clear of the
   // driver and the monitor.
   task automatic wait_drained();
      while (words_accepted != words_queued || expected_pixels.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_frame_reg(logic [CSR_INDEX_BITS-1:0] reg_index,
                                  logic [DIM_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (reg_index == CSR_FRAME_WIDTH) begin
         frame_width_q = value;
      end else begin
         frame_height_q = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One frame setting: drain, let a possible final divide finish, write both
   // registers, then run random words with a full drain halfway through. With
   // hold_off set, a long line starts first and the pixel side is held off
   // while its ticks keep coming, so the block fills and stalls its input.
   task automatic run_phase(int width, int height, int send_pct, int stall_pct,
                            int n_words, bit hold_off);
      int mark;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_frame_reg(CSR_FRAME_WIDTH, DIM_BITS'(width));
      write_frame_reg(CSR_FRAME_HEIGHT, DIM_BITS'(height));
      frame_settings++;
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      if (hold_off) begin
         mark = words_queued + 4;
         queue_line(10, 10, 110, 50, $urandom, 100);
         while (words_accepted < mark) begin
            @(negedge clock);
         end
         @(posedge clock);
         rsp_hold_left = HOLD_CYCLES;
      end
      queue_random_words(n_words / 2);
      wait_drained();
      queue_random_words(n_words - n_words / 2);
   endtask

   initial begin
      // Directed words, run against the reset frame of 800 by 600.
      queue_tick();                                         // tick with no line
      queue_line(7, 7, 7, 7, 32'h1234_5678, 1);             // zero length, then a tick
      queue_line(0, 0, 2, 1, 32'h00FF_00FF, 3);             // y of 0.5 rounds up; extra tick
      queue_line(0, 0, -2, -1, 32'hFF00_FF00, 2);           // y of -0.5 rounds down
      queue_line(5, 5, 4, 7, 32'hA5A5_5A5A, 2);             // steep, x of 4.5 rounds to 5
      queue_line(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 2);  // longest line
      queue_line(32767, 32767, 32765, -32768, 32'h0000_0000, 1);   // cut off by next start
      queue_line(799, 599, 801, 601, 32'h8000_0001, 2);     // last in-frame corner, then out
      queue_line(-1, 0, 1, 0, 32'h7FFF_FFFE, 2);            // enters the frame from the left

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      run_phase(1, 1, 26, 61, 115, 1'b0);
      run_phase(16383, 16383, 26, 61, 115, 1'b0);
      run_phase(0, 600, 61, 26, 115, 1'b0);
      run_phase(320, 0, 61, 26, 115, 1'b0);
      run_phase($urandom_range(8192, 1), $urandom_range(8192, 1), 0, 0, 115, 1'b1);
      run_phase(800, 600, 0, 0, 115, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_mismatch($sformatf("%0d pixel words never arrived", expected_pixels.size()));
      end

      $display("Ran %0d command words (%0d line starts) and checked %0d pixel words",
               words_accepted, starts_accepted, pixels_checked);
      $display("over %0d frame sizes, with sender gaps, receiver stalls and a long hold-off.",
               frame_settings);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/dda_pkg.sv
rtl/dda_div.sv
rtl/dda_line_rasterizer.sv
test/dda_line_rasterizer_tb.sv
